// File: sv/itda_pkg.sv
// Shared constants and types for the integer to decimal ASCII converter.
// No dependencies; imported by every module of the block.
package itda_pkg;

  localparam int VALUE_W    = 32;
  localparam int NUM_DIGITS = 10;
  localparam int DIGIT_W    = 4;
  localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int CHAR_W     = 8;
  localparam int STEP_CNT_W = $clog2(VALUE_W);
  localparam int POS_W      = $clog2(NUM_DIGITS);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

  typedef logic [BCD_W-1:0]   bcd_t;
  typedef logic [VALUE_W-1:0] bin_t;

  // Working word of the shift-add-3 converter: BCD digits above, binary below.
  typedef struct packed {
    bcd_t bcd;
    bin_t bin;
  } conv_t;

endpackage

// File: sv/itda_bcd_step.sv
// One shift-add-3 step of binary to BCD conversion.
// Depends on itda_pkg.
module itda_bcd_step (
  input  itda_pkg::conv_t cur,
  output itda_pkg::conv_t nxt
);
  import itda_pkg::*;

  bcd_t adj;

  // Add 3 to each digit of 5 or more so the shift carries correctly.
  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (cur.bcd[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        adj[d*DIGIT_W +: DIGIT_W] = cur.bcd[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        adj[d*DIGIT_W +: DIGIT_W] = cur.bcd[d*DIGIT_W +: DIGIT_W];
      end
    end
  end

  assign nxt.bcd = {adj[BCD_W-2:0], cur.bin[VALUE_W-1]};
  assign nxt.bin = {cur.bin[VALUE_W-2:0], 1'b0};

endmodule

// File: sv/int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text, one character per output beat.
// After input accept, 32 passes through the shared shift-add-3 step and a leading-digit step come
// before the first character is loaded into the output register. Each number gives n = 1..11
// characters, one per output beat, and a new number is accepted only once back in idle.
// Reset (rst, synchronous): back to idle, output register empty; no memories to clear.
// Depends on itda_pkg and itda_bcd_step.
module int_to_decimal_ascii (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [31:0]            value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [itda_pkg::CHAR_W-1:0]   character,
  output logic                          last
);
  import itda_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_LEAD = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [STEP_CNT_W-1:0] cnt;
  logic [POS_W-1:0]      pos;
  logic [POS_W-1:0]      lead_pos;
  logic                  sign_pend;
  conv_t                 work;
  conv_t                 step_out;
  logic                  slot_free;
  logic [DIGIT_W-1:0]    cur_digit;

  // Shared arithmetic: one shift-add-3 pass per CONV cycle.
  itda_bcd_step u_step (
    .cur (work),
    .nxt (step_out)
  );

  assign in_ready  = (state == ST_IDLE);
  // Output register can take a new beat when empty or being drained this cycle.
  assign slot_free = !out_valid || out_ready;

  // Most significant nonzero digit; zero keeps position 0 so "0" is emitted.
  always_comb begin
    lead_pos = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (work.bcd[d*DIGIT_W +: DIGIT_W] != '0) begin
        lead_pos = POS_W'(d);
      end
    end
  end

  always_comb begin
    cur_digit = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (pos == POS_W'(d)) begin
        cur_digit = work.bcd[d*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CONV;
      end
      ST_CONV: begin
        if (cnt == STEP_CNT_W'(VALUE_W - 1)) state_next = ST_LEAD;
      end
      ST_LEAD: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free && !sign_pend && pos == '0) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == ST_EMIT && slot_free) out_valid <= 1'b1;
    end
  end

  // Datapath: capture magnitude, iterate, then walk the digits down.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          sign_pend <= value[VALUE_W-1];
          work.bcd  <= '0;
          // Unsigned negate keeps the most negative value exact.
          work.bin  <= value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;
          cnt       <= '0;
        end
      end
      ST_CONV: begin
        work <= step_out;
        cnt  <= cnt + STEP_CNT_W'(1);
      end
      ST_LEAD: begin
        pos <= lead_pos;
      end
      ST_EMIT: begin
        if (slot_free) begin
          if (sign_pend) begin
            character <= CHAR_MINUS;
            last      <= 1'b0;
            sign_pend <= 1'b0;
          end else begin
            character <= CHAR_ZERO + CHAR_W'(cur_digit);
            last      <= (pos == '0);
            if (pos != '0) pos <= pos - POS_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// File: sv/itda_checker.sv
// Port-level assertions for int_to_decimal_ascii, attached by bind.
// Depends on itda_pkg and the top level's port list.
module itda_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [itda_pkg::CHAR_W-1:0] character,
  input logic                        last
);
  import itda_pkg::*;

  // Every beat carries a minus sign or a decimal digit.
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (character == CHAR_MINUS) ||
                  (character >= CHAR_ZERO && character <= CHAR_ZERO + CHAR_W'(9)))
    else $error("output character outside sign and digit codes");

  // A sign never ends the text.
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && character == CHAR_MINUS) |-> !last)
    else $error("minus sign flagged as last");

  // Accepting a number keeps the input closed during conversion.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after accept");

  // A stalled beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(character) && $stable(last))
    else $error("output beat changed while stalled");

endmodule

bind int_to_decimal_ascii itda_checker u_itda_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .character (character),
  .last      (last)
);
